@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

@@ rtl/dfso_pkg.sv @@
package dfso_pkg;

  // fixed field widths of the item format
  localparam int NODE_W = 3;
  localparam int ROW_W  = 8;
  localparam int RES_W  = 4;
  localparam int ROWS   = 8;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // result of the neighbor search
  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] idx;
  } pick_t;

  // traversal sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_POP    = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage

@@ rtl/dfs_adjacency_matrix_order.sv @@
// Depth-first traversal of a directed graph of up to eight reachable nodes.
// Input channel (in_valid/in_ready): command 0 loads row_index with the edge
// mask row_bits; command 1 clears the visited set and walks the graph from
// start_node, neighbors in ascending order.
// Output channel (out_valid/out_ready): one transfer per visited node, in
// visit order; is_last marks the final node. A load gives no transfer, and
// neither does a start at a node at or above NODES.
// Sequencing: a start keeps in_ready low after its transfer while it walks:
// each push is one priority-encoder pass over the top node's row, each pop
// but the last waits on a stack memory read, and a finish step releases the
// final result. in_ready is high only between traversals.
// Each result leaves one push behind the search, since is_last is only known
// once the stack empties.
// A stalled receiver holds the search at its next push; the final result may
// wait in the output register while the next item is taken.
// Reset clears the adjacency rows, the visited set and the stack depth.
`include "assert_macros.svh"

module dfs_adjacency_matrix_order #(
  parameter int NODES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [dfso_pkg::NODE_W-1:0]  row_index,
  input  logic [dfso_pkg::ROW_W-1:0]   row_bits,
  input  logic [dfso_pkg::NODE_W-1:0]  start_node,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dfso_pkg::NODE_W-1:0]  node,
  output logic                         is_last
);

  localparam int ADDR_W  = $clog2(NODES);
  localparam int DEPTH_W = $clog2(NODES + 1);
  localparam int ENT_W   = dfso_pkg::NODE_W + dfso_pkg::RES_W;

  dfso_pkg::state_t state;

  logic [dfso_pkg::ROW_W-1:0]  adj [dfso_pkg::ROWS];
  logic [dfso_pkg::ROW_W-1:0]  visited;
  logic [DEPTH_W-1:0]          depth;
  logic [dfso_pkg::NODE_W-1:0] top_node;
  logic [dfso_pkg::RES_W-1:0]  top_res;
  logic [dfso_pkg::NODE_W-1:0] pend_node;

  logic [dfso_pkg::ROW_W-1:0]  edge_ok;
  logic [dfso_pkg::ROW_W-1:0]  res_mask;
  logic [dfso_pkg::ROW_W-1:0]  cand;
  dfso_pkg::pick_t             pk;

  logic                        in_xfer;
  logic                        slot_free;
  logic                        room;
  logic                        push;
  logic                        pop;
  logic                        emit;
  logic [DEPTH_W-1:0]          lvl;
  logic [DEPTH_W-1:0]          lvl_below;
  logic [dfso_pkg::RES_W-1:0]  res_next;
  logic [ENT_W-1:0]            wr_data;
  logic [ENT_W-1:0]            rd_data;
  logic                        row_ok;
  logic                        start_ok;

  assign in_ready  = (state == dfso_pkg::S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign row_ok    = (32'(row_index) < NODES);
  assign start_ok  = (32'(start_node) < NODES);

  // candidate neighbors of the top node: edge, in range, unvisited, not yet tried
  always_comb begin
    for (int i = 0; i < dfso_pkg::ROW_W; i++) begin
      edge_ok[i]  = (i < NODES);
      res_mask[i] = (dfso_pkg::RES_W'(i) >= top_res);
    end
    cand = adj[top_node] & ~visited & edge_ok & res_mask;
  end

  dfso_pick u_pick (
    .cand (cand),
    .pick (pk)
  );

  // push/pop decisions of the sequencer
  assign room      = (depth < DEPTH_W'(NODES));
  assign push      = (state == dfso_pkg::S_SCAN) && pk.found && room && slot_free;
  assign pop       = (state == dfso_pkg::S_SCAN) && !(pk.found && room);
  assign emit      = push || ((state == dfso_pkg::S_FINISH) && slot_free);
  assign lvl       = depth - 1'b1;
  assign lvl_below = depth - 2'd2;
  assign res_next  = {1'b0, pk.idx} + 1'b1;
  assign wr_data   = {top_node, res_next};

  // stack of saved levels below the top
  dfso_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODES)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (lvl[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (pop),
    .rd_addr (lvl_below[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dfso_pkg::S_IDLE;
      visited   <= '0;
      depth     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < dfso_pkg::ROWS; i++) begin
        adj[i] <= '0;
      end
    end else begin
      // output valid: set on a new result, cleared on its transfer
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        dfso_pkg::S_IDLE: begin
          if (in_xfer) begin
            if (command == dfso_pkg::CMD_LOAD) begin
              if (row_ok) begin
                adj[row_index] <= row_bits;
              end
            end else begin
              visited <= start_ok ? (dfso_pkg::ROW_W'(1) << start_node) : '0;
              if (start_ok) begin
                depth <= DEPTH_W'(1);
                state <= dfso_pkg::S_SCAN;
              end
            end
          end
        end
        dfso_pkg::S_SCAN: begin
          if (push) begin
            visited[pk.idx] <= 1'b1;
            depth           <= depth + 1'b1;
          end else if (pop) begin
            depth <= lvl;
            if (depth == DEPTH_W'(1)) begin
              state <= dfso_pkg::S_FINISH;
            end else begin
              state <= dfso_pkg::S_POP;
            end
          end
        end
        dfso_pkg::S_POP: begin
          state <= dfso_pkg::S_SCAN;
        end
        dfso_pkg::S_FINISH: begin
          if (slot_free) begin
            state <= dfso_pkg::S_IDLE;
          end
        end
        default: begin
          state <= dfso_pkg::S_IDLE;
        end
      endcase
    end
  end

  // top-of-stack, held-back result and output payload
  always_ff @(posedge clk) begin
    case (state)
      dfso_pkg::S_IDLE: begin
        top_node  <= start_node;
        top_res   <= '0;
        pend_node <= start_node;
      end
      dfso_pkg::S_SCAN: begin
        if (push) begin
          node      <= pend_node;
          is_last   <= 1'b0;
          pend_node <= pk.idx;
          top_node  <= pk.idx;
          top_res   <= '0;
        end
      end
      dfso_pkg::S_POP: begin
        top_node <= rd_data[ENT_W-1:dfso_pkg::RES_W];
        top_res  <= rd_data[dfso_pkg::RES_W-1:0];
      end
      dfso_pkg::S_FINISH: begin
        if (slot_free) begin
          node    <= pend_node;
          is_last <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `ASSERT_NEVER(a_depth_bound, clk, rst, depth > DEPTH_W'(NODES))
  `ASSERT_CLK(a_idle_empty, clk, rst, in_ready |-> depth == '0)
  `ASSERT_CLK(a_push_unvisited, clk, rst, push |-> !visited[pk.idx])
  `ASSERT_CLK(a_finish_last, clk, rst,
    (state == dfso_pkg::S_FINISH && slot_free) |=> (out_valid && is_last))

endmodule

@@ rtl/dfso_ram.sv @@
module dfso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/dfso_pick.sv @@
module dfso_pick (
  input  logic [dfso_pkg::ROW_W-1:0] cand,
  output dfso_pkg::pick_t            pick
);

  // lowest set bit wins: scan from the top so the last hit is the lowest
  always_comb begin
    pick.found = 1'b0;
    pick.idx   = '0;
    for (int i = dfso_pkg::ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick.found = 1'b1;
        pick.idx   = dfso_pkg::NODE_W'(i);
      end
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int NODES        = 8;
  localparam int IDLE_PCT     = 7;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  // one row of the directed stimulus; solo marks a start whose only visit is the root
  typedef struct packed {
    logic                        cmd;
    logic [dfso_pkg::NODE_W-1:0] row;
    logic [dfso_pkg::ROW_W-1:0]  bits;
    logic [dfso_pkg::NODE_W-1:0] start;
    logic                        solo;
  } stim_t;

  typedef struct packed {
    logic [dfso_pkg::NODE_W-1:0] node;
    logic                        last;
  } visit_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic                        command;
  logic [dfso_pkg::NODE_W-1:0] row_index;
  logic [dfso_pkg::ROW_W-1:0]  row_bits;
  logic [dfso_pkg::NODE_W-1:0] start_node;
  logic                        out_valid;
  logic                        out_ready;
  logic [dfso_pkg::NODE_W-1:0] node;
  logic                        is_last;

  // local copy of the adjacency matrix and the visits still owed by the block
  logic [dfso_pkg::ROW_W-1:0] graph_rows [dfso_pkg::ROWS];
  visit_t                     visit_q [$];

  int cycles      = 0;
  int mismatches  = 0;
  int items_in    = 0;
  int starts_in   = 0;
  int visits_seen = 0;
  bit no_idle;

  // directed part: empty graph, full fan-out, deepest chain, self loop, back edges
  stim_t plan [21] = '{
    // nothing loaded yet, so a start visits only its root
    '{dfso_pkg::CMD_START, 3'd5, 8'hA5, 3'd0, 1'b1},
    '{dfso_pkg::CMD_START, 3'd2, 8'hFF, 3'd7, 1'b1},
    // row 0 reaches every node, itself included
    '{dfso_pkg::CMD_LOAD,  3'd0, 8'hFF, 3'd6, 1'b0},
    '{dfso_pkg::CMD_START, 3'd0, 8'h00, 3'd0, 1'b0},
    '{dfso_pkg::CMD_START, 3'd7, 8'h00, 3'd3, 1'b1},
    // chain 7 -> 6 -> ... -> 0 fills the whole stack
    '{dfso_pkg::CMD_LOAD,  3'd7, 8'h40, 3'd0, 1'b0},
    '{dfso_pkg::CMD_LOAD,  3'd6, 8'h20, 3'd7, 1'b0},
    '{dfso_pkg::CMD_LOAD,  3'd5, 8'h10, 3'd0, 1'b0},
    '{dfso_pkg::CMD_LOAD,  3'd4, 8'h08, 3'd0, 1'b0},
    '{dfso_pkg::CMD_LOAD,  3'd3, 8'h04, 3'd0, 1'b0},
    '{dfso_pkg::CMD_LOAD,  3'd2, 8'h02, 3'd0, 1'b0},
    '{dfso_pkg::CMD_LOAD,  3'd1, 8'h01, 3'd0, 1'b0},
    '{dfso_pkg::CMD_START, 3'd0, 8'h00, 3'd7, 1'b0},
    // a self loop alone leads nowhere
    '{dfso_pkg::CMD_LOAD,  3'd2, 8'h04, 3'd0, 1'b0},
    '{dfso_pkg::CMD_START, 3'd1, 8'h7E, 3'd2, 1'b1},
    // empty row 0 again
    '{dfso_pkg::CMD_LOAD,  3'd0, 8'h00, 3'd0, 1'b0},
    '{dfso_pkg::CMD_START, 3'd0, 8'h00, 3'd0, 1'b1},
    // alternating masks with back edges
    '{dfso_pkg::CMD_LOAD,  3'd5, 8'hAA, 3'd0, 1'b0},
    '{dfso_pkg::CMD_LOAD,  3'd4, 8'h55, 3'd0, 1'b0},
    '{dfso_pkg::CMD_START, 3'd3, 8'hC3, 3'd5, 1'b0},
    '{dfso_pkg::CMD_START, 3'd7, 8'h3C, 3'd1, 1'b0}
  };

  dfs_adjacency_matrix_order #(
    .NODES(NODES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .row_index (row_index),
    .row_bits  (row_bits),
    .start_node(start_node),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .node      (node),
    .is_last   (is_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // depth-first walk from root over graph_rows, neighbors in ascending order
  task automatic predict_walk(input logic [dfso_pkg::NODE_W-1:0] root);
    logic [dfso_pkg::NODE_W-1:0] path [NODES];
    int                          resume [NODES];
    logic [NODES-1:0]            seen;
    logic [dfso_pkg::ROW_W-1:0]  mask;
    visit_t                      found_q [$];
    visit_t                      tail;
    int                          depth;
    int                          r;
    seen = '0;
    if (root >= NODES) return;
    seen[root] = 1'b1;
    tail.node = root;
    tail.last = 1'b0;
    found_q.push_back(tail);
    path[0] = root;
    resume[0] = 0;
    depth = 1;
    while (depth > 0) begin
      mask = graph_rows[path[depth-1]];
      r = resume[depth-1];
      while (r < NODES && !(mask[r] && !seen[r])) r++;
      if (r < NODES && depth < NODES) begin
        resume[depth-1] = r + 1;
        seen[r] = 1'b1;
        tail.node = dfso_pkg::NODE_W'(r);
        tail.last = 1'b0;
        found_q.push_back(tail);
        path[depth] = dfso_pkg::NODE_W'(r);
        resume[depth] = 0;
        depth++;
      end else begin
        depth--;
      end
    end
    // the final visit carries the last flag
    tail = found_q.pop_back();
    tail.last = 1'b1;
    found_q.push_back(tail);
    foreach (found_q[i]) visit_q.push_back(found_q[i]);
  endtask

  task automatic report_mismatch(input string what, input bit have_want,
                                 input visit_t want, input visit_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want)
        $display("%s at cycle %0d: expected node %0d last %0b, got node %0d last %0b",
                 what, cycles, want.node, want.last, got.node, got.last);
      else
        $display("%s at cycle %0d: nothing expected, got node %0d last %0b",
                 what, cycles, got.node, got.last);
    end
  endtask

  // drive one item, wait for its transfer, then update the prediction
  task automatic issue_item(input stim_t s);
    visit_t one;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= s.cmd;
    row_index  <= s.row;
    row_bits   <= s.bits;
    start_node <= s.start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_in++;
    if (s.cmd == dfso_pkg::CMD_LOAD) begin
      if (s.row < NODES) graph_rows[s.row] = s.bits;
    end else begin
      starts_in++;
      if (s.solo) begin
        one.node = s.start;
        one.last = 1'b1;
        visit_q.push_back(one);
      end else begin
        predict_walk(s.start);
      end
    end
  endtask

  // random loads of sparse, dense, empty and arbitrary rows mixed with starts
  function automatic stim_t random_item();
    stim_t s;
    s.cmd   = ($urandom_range(99) < 30) ? dfso_pkg::CMD_START : dfso_pkg::CMD_LOAD;
    s.row   = dfso_pkg::NODE_W'($urandom_range(dfso_pkg::ROWS-1));
    s.start = dfso_pkg::NODE_W'($urandom_range(dfso_pkg::ROWS-1));
    s.solo  = 1'b0;
    case ($urandom_range(3))
      0: s.bits = dfso_pkg::ROW_W'($urandom_range(255));
      1: s.bits = dfso_pkg::ROW_W'(1 << $urandom_range(dfso_pkg::ROW_W-1)) |
                  dfso_pkg::ROW_W'(1 << $urandom_range(dfso_pkg::ROW_W-1));
      2: s.bits = ~dfso_pkg::ROW_W'(1 << $urandom_range(dfso_pkg::ROW_W-1));
      default: s.bits = '0;
    endcase
    return s;
  endfunction

  // sink side: random stalls, none during the steady stretch
  always @(posedge clk) begin
    out_ready <= !rst && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  // check each output transfer against the oldest predicted visit
  always @(posedge clk) begin
    visit_t want;
    visit_t got;
    if (!rst && out_valid && out_ready) begin
      got.node = node;
      got.last = is_last;
      visits_seen++;
      if (visit_q.size() == 0) begin
        report_mismatch("unexpected transfer", 1'b0, '0, got);
      end else begin
        want = visit_q.pop_front();
        if (got.node !== want.node || got.last !== want.last)
          report_mismatch("wrong visit", 1'b1, want, got);
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d visits still owed", cycles, visit_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = dfso_pkg::CMD_LOAD;
    row_index  = '0;
    row_bits   = '0;
    start_node = '0;
    no_idle    = 1'b0;
    foreach (graph_rows[i]) graph_rows[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue_item(plan[i]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle <= (n >= 150 && n < 260);
      issue_item(random_item());
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    // drain the owed visits, then watch for stray transfers
    while (visit_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items transferred in, %0d of them traversals", items_in, starts_in);
    $display("%0d visited nodes checked in depth-first order, %0d mismatches",
             visits_seen, mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
